>>> rtl/wstd_pkg.sv
`timescale 1ns / 1ps
// Package for the work-stealing task dispatcher: request and result beat types,
// request codes, controller command struct and parameter defaults. No dependencies.
package wstd_pkg;

    localparam int WORKERS_DEF     = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_FETCH = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  queue_index;
        logic [15:0] task_handle;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [15:0] given_handle;
        logic [1:0]  source_queue;
        logic        stolen;
        logic        overflow;
        logic [6:0]  pending_count;
    } t_rsp;

    typedef struct packed {
        logic capture;   // latch the request beat
        logic execute;   // update queues, access the store
    } t_ctl_cmd;

endpackage

>>> rtl/wstd_ctrl.sv
`timescale 1ns / 1ps
// Controller of the dispatcher: accept / execute / respond sequencing.
// Depends on wstd_pkg.
module wstd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output logic                o_valid,
    output wstd_pkg::t_ctl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_valid;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = accept ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state == S_EXEC);
            r_valid <= (n_state == S_RESP);
        end
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

>>> rtl/wstd_datapath.sv
`timescale 1ns / 1ps
// Datapath of the dispatcher: per-worker deque pointers, task store,
// victim pick and pending counter. Depends on wstd_pkg.
module wstd_datapath #(
    parameter int WORKERS     = wstd_pkg::WORKERS_DEF,
    parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wstd_pkg::t_ctl_cmd i_cmd,
    input  wstd_pkg::t_req     i_req,
    output wstd_pkg::t_rsp     o_rsp
);

    localparam int QW       = $clog2(WORKERS);
    localparam int FW       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int SW       = FW + 1;
    localparam int SLOTS    = WORKERS * QUEUE_DEPTH;
    localparam int AW       = $clog2(SLOTS);
    localparam int PEND_CAP = (SLOTS < 127) ? SLOTS : 127;

    wstd_pkg::t_req r_req;

    logic [FW-1:0] r_front [WORKERS];
    logic [CW-1:0] r_count [WORKERS];
    logic [6:0]    r_pending;
    logic [15:0]   r_store [SLOTS];
    logic [15:0]   r_rd_data;
    logic          r_found;
    logic [1:0]    r_src;
    logic          r_stolen;
    logic          r_ovf;

    logic [4:0]         q_ext;
    logic [QW-1:0]      q;
    logic [4:0]         v_ext;
    logic [WORKERS-1:0] nonempty;
    logic               own_hit;
    logic               vict_hit;
    logic [QW-1:0]      vict_q;
    logic [QW-1:0]      tq;
    logic [FW-1:0]      tq_front;
    logic [CW-1:0]      tq_count;
    logic               full;
    logic [FW-1:0]      front_dec;
    logic [FW-1:0]      front_inc;
    logic [SW-1:0]      back_sum;
    logic [FW-1:0]      back_slot;

    logic          wr_en;
    logic          rd_en;
    logic          upd_front;
    logic [FW-1:0] n_front;
    logic          cnt_inc;
    logic          cnt_dec;
    logic [FW-1:0] slot;
    logic [AW-1:0] addr;
    logic          pend_inc;
    logic          pend_dec;
    logic          n_found;
    logic          n_stolen;
    logic          n_ovf;

    // queue index reduced modulo WORKERS (value < 2*WORKERS)
    always_comb begin
        q_ext = 5'(r_req.queue_index);
        if (q_ext >= 5'(WORKERS)) begin
            q_ext = q_ext - 5'(WORKERS);
        end
        q = q_ext[QW-1:0];
    end

    always_comb begin
        for (int w = 0; w < WORKERS; w++) begin
            nonempty[w] = (r_count[w] != '0);
        end
    end

    assign own_hit = nonempty[q];

    // rotating priority pick: nearest victim after q wins
    always_comb begin
        vict_hit = 1'b0;
        vict_q   = '0;
        v_ext    = '0;
        for (int j = WORKERS - 1; j >= 1; j--) begin
            v_ext = 5'(q) + 5'(j);
            if (v_ext >= 5'(WORKERS)) begin
                v_ext = v_ext - 5'(WORKERS);
            end
            if (nonempty[v_ext[QW-1:0]]) begin
                vict_hit = 1'b1;
                vict_q   = v_ext[QW-1:0];
            end
        end
    end

    assign tq       = (r_req.req_type == wstd_pkg::REQ_FETCH && !own_hit) ? vict_q : q;
    assign tq_front = r_front[tq];
    assign tq_count = r_count[tq];
    assign full     = (tq_count == CW'(QUEUE_DEPTH));

    assign front_dec = (tq_front == '0) ? FW'(QUEUE_DEPTH - 1) : tq_front - 1'b1;
    assign front_inc = (tq_front == FW'(QUEUE_DEPTH - 1)) ? '0 : tq_front + 1'b1;

    always_comb begin
        back_sum = SW'(tq_front) + SW'(tq_count) - 1'b1;
        if (back_sum >= SW'(QUEUE_DEPTH)) begin
            back_sum = back_sum - SW'(QUEUE_DEPTH);
        end
        back_slot = back_sum[FW-1:0];
    end

    always_comb begin
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        upd_front = 1'b0;
        n_front   = tq_front;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        slot      = tq_front;
        pend_inc  = 1'b0;
        pend_dec  = 1'b0;
        n_found   = 1'b0;
        n_stolen  = 1'b0;
        n_ovf     = 1'b0;
        case (r_req.req_type)
            wstd_pkg::REQ_PUSH: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en     = 1'b1;
                    upd_front = 1'b1;
                    n_front   = front_dec;
                    slot      = front_dec;
                    cnt_inc   = 1'b1;
                    pend_inc  = (r_pending < 7'(PEND_CAP));
                end
            end
            wstd_pkg::REQ_FETCH: begin
                if (own_hit) begin
                    rd_en     = 1'b1;
                    upd_front = 1'b1;
                    n_front   = front_inc;
                    cnt_dec   = 1'b1;
                    n_found   = 1'b1;
                end else if (vict_hit) begin
                    rd_en     = 1'b1;
                    slot      = back_slot;
                    cnt_dec   = 1'b1;
                    n_found   = 1'b1;
                    n_stolen  = 1'b1;
                end
            end
            wstd_pkg::REQ_DONE: begin
                pend_dec = (r_pending != '0);
            end
            default: begin
            end
        endcase
    end

    assign addr = AW'(AW'(tq) * AW'(QUEUE_DEPTH) + AW'(slot));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.execute) begin
            r_found  <= n_found;
            r_src    <= 2'(tq);
            r_stolen <= n_stolen;
            r_ovf    <= n_ovf;
        end
    end

    // task store: one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && wr_en) begin
            r_store[addr] <= r_req.task_handle;
        end
        if (i_cmd.execute && rd_en) begin
            r_rd_data <= r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORKERS; w++) begin
                r_front[w] <= '0;
                r_count[w] <= '0;
            end
            r_pending <= '0;
        end else if (i_cmd.execute) begin
            if (upd_front) begin
                r_front[tq] <= n_front;
            end
            if (cnt_inc) begin
                r_count[tq] <= tq_count + 1'b1;
            end else if (cnt_dec) begin
                r_count[tq] <= tq_count - 1'b1;
            end
            if (pend_inc) begin
                r_pending <= r_pending + 1'b1;
            end else if (pend_dec) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    assign o_rsp.found         = r_found;
    assign o_rsp.given_handle  = r_found ? r_rd_data : '0;
    assign o_rsp.source_queue  = r_found ? r_src : '0;
    assign o_rsp.stolen        = r_stolen;
    assign o_rsp.overflow      = r_ovf;
    assign o_rsp.pending_count = r_pending;

endmodule

>>> rtl/work_stealing_task_dispatcher.sv
`timescale 1ns / 1ps
// Work-stealing task dispatcher. Result strobe o_valid is high in the
// respond state, which follows the execute state of the accepted beat.
// The single-port task store access and the pointer update share the
// execute cycle, and a new beat is taken while the result is shown.
// Synchronous active-low reset empties all queues and clears the pending
// count; the store keeps its contents.
module work_stealing_task_dispatcher #(
    parameter int WORKERS     = wstd_pkg::WORKERS_DEF,
    parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  wstd_pkg::t_req  i_req,
    output logic            o_valid,
    output wstd_pkg::t_rsp  o_rsp
);

    wstd_pkg::t_ctl_cmd cmd;

    wstd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    wstd_datapath #(
        .WORKERS     (WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

>>> rtl/wstd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the dispatcher, bound to the top level.
// Depends on wstd_pkg and work_stealing_task_dispatcher.
module wstd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input wstd_pkg::t_rsp o_rsp
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted beat");

    a_result_two_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_valid)
        else $error("result beat missing two cycles after accept");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_empty_fetch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.found |->
            o_rsp.given_handle == '0 && o_rsp.source_queue == '0 && !o_rsp.stolen)
        else $error("task fields set without a found task");

    a_found_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.found && o_rsp.overflow))
        else $error("fetch and overflow flagged together");

endmodule

bind work_stealing_task_dispatcher wstd_checker u_wstd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for work_stealing_task_dispatcher: directed and random push/fetch/complete
// beats checked against an in-bench deque predictor. Depends on rtl/wstd_pkg.sv and the RTL.
module testbench;

    localparam int NW = wstd_pkg::WORKERS_DEF;
    localparam int ND = wstd_pkg::QUEUE_DEPTH_DEF;
    localparam int PENDING_CAP = (NW * ND < 127) ? NW * ND : 127;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_TAIL = 100;   // last beats go out back to back
    localparam int MODE_FILL = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    wstd_pkg::t_req req_beat = '0;
    logic o_valid;
    wstd_pkg::t_rsp o_rsp;

    work_stealing_task_dispatcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req_beat),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // shadow copy of the deques
    logic [15:0] shadow_store [NW][ND];
    int q_front [NW];
    int q_count [NW];
    int pending_total;

    wstd_pkg::t_req pending_reqs[$];
    wstd_pkg::t_rsp expected_rsps[$];
    int errors = 0;
    int idle_left = 0;
    bit gap_stretch = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic wstd_pkg::t_rsp dispatch_predict(wstd_pkg::t_req r);
        wstd_pkg::t_rsp o;
        int q;
        int v;
        int j;
        bit hunting;
        o = '0;
        q = int'(r.queue_index) % NW;
        case (r.req_type)
            wstd_pkg::REQ_PUSH: begin
                if (q_count[q] >= ND) begin
                    o.overflow = 1'b1;
                end else begin
                    q_front[q] = (q_front[q] + ND - 1) % ND;
                    shadow_store[q][q_front[q]] = r.task_handle;
                    q_count[q]++;
                    if (pending_total < PENDING_CAP) pending_total++;
                end
            end
            wstd_pkg::REQ_FETCH: begin
                if (q_count[q] != 0) begin
                    o.found = 1'b1;
                    o.given_handle = shadow_store[q][q_front[q]];
                    o.source_queue = q[1:0];
                    q_front[q] = (q_front[q] + 1) % ND;
                    q_count[q]--;
                end else begin
                    // steal from the back of the first non-empty victim
                    hunting = 1'b1;
                    for (j = 1; j < NW; j++) begin
                        v = (q + j) % NW;
                        if (hunting && q_count[v] != 0) begin
                            hunting = 1'b0;
                            o.found = 1'b1;
                            o.stolen = 1'b1;
                            o.given_handle = shadow_store[v][(q_front[v] + q_count[v] - 1) % ND];
                            o.source_queue = v[1:0];
                            q_count[v]--;
                        end
                    end
                end
            end
            wstd_pkg::REQ_DONE: begin
                if (pending_total != 0) pending_total--;
            end
            default: ;
        endcase
        o.pending_count = 7'(pending_total);
        return o;
    endfunction

    function automatic wstd_pkg::t_req make_req(logic [1:0] kind, int q, logic [15:0] handle);
        wstd_pkg::t_req r;
        r.req_type = kind;
        r.queue_index = 2'(q);
        r.task_handle = handle;
        return r;
    endfunction

    function automatic void add_req(wstd_pkg::t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic wstd_pkg::t_req random_req(int mode);
        int roll;
        logic [1:0] kind;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  kind = (roll < 85) ? wstd_pkg::REQ_PUSH :
                               (roll < 95) ? wstd_pkg::REQ_FETCH :
                               (roll < 98) ? wstd_pkg::REQ_DONE : REQ_UNUSED;
            MODE_DRAIN: kind = (roll < 75) ? wstd_pkg::REQ_FETCH :
                               (roll < 95) ? wstd_pkg::REQ_DONE :
                               (roll < 98) ? wstd_pkg::REQ_PUSH : REQ_UNUSED;
            default:    kind = (roll < 40) ? wstd_pkg::REQ_PUSH :
                               (roll < 75) ? wstd_pkg::REQ_FETCH :
                               (roll < 97) ? wstd_pkg::REQ_DONE : REQ_UNUSED;
        endcase
        return make_req(kind, $urandom_range(0, NW - 1), 16'($urandom()));
    endfunction

    // driver: a beat is taken on an edge with start high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_rsps.insert(expected_rsps.size(), dispatch_predict(req_beat));
                pending_reqs.delete(0);
                if ($urandom_range(0, 19) == 0) gap_stretch = ~gap_stretch;
                if (gap_stretch && pending_reqs.size() > QUIET_TAIL &&
                    $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 5);
            end
            if (start && busy) begin
                // hold the beat until it is taken
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                start <= 1'b1;
                req_beat <= pending_reqs[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: each strobe is one result beat
    always @(posedge i_clk) begin
        wstd_pkg::t_rsp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_rsp);
                errors++;
            end else begin
                want = expected_rsps[0];
                expected_rsps.delete(0);
                check_field("found", 16'(want.found), 16'(o_rsp.found));
                check_field("given_handle", want.given_handle, o_rsp.given_handle);
                check_field("source_queue", 16'(want.source_queue), 16'(o_rsp.source_queue));
                check_field("stolen", 16'(want.stolen), 16'(o_rsp.stolen));
                check_field("overflow", 16'(want.overflow), 16'(o_rsp.overflow));
                check_field("pending_count", 16'(want.pending_count), 16'(o_rsp.pending_count));
            end
        end
    end

    initial begin
        int i;
        int issued;
        int mode;
        int run;
        int k;
        wstd_pkg::t_req r;
        for (i = 0; i < NW; i++) begin
            q_front[i] = 0;
            q_count[i] = 0;
        end
        pending_total = 0;

        // directed: empty-state corners, own pop vs steal, full queue
        add_req(make_req(wstd_pkg::REQ_DONE, 0, 16'h0000));
        add_req(make_req(wstd_pkg::REQ_FETCH, 1, 16'hFFFF));
        add_req(make_req(REQ_UNUSED, 2, 16'hA5A5));
        add_req(make_req(wstd_pkg::REQ_PUSH, 0, 16'h0000));
        add_req(make_req(wstd_pkg::REQ_PUSH, 0, 16'hFFFF));
        add_req(make_req(wstd_pkg::REQ_FETCH, 0, 16'h0000));
        add_req(make_req(wstd_pkg::REQ_FETCH, 1, 16'h0000));
        for (i = 0; i < ND; i++)
            add_req(make_req(wstd_pkg::REQ_PUSH, 3, 16'h1 << i));
        add_req(make_req(wstd_pkg::REQ_PUSH, 3, 16'h5A5A));
        add_req(make_req(wstd_pkg::REQ_FETCH, 0, 16'h0000));
        add_req(make_req(wstd_pkg::REQ_FETCH, 3, 16'h0000));

        // each random round picks filling, draining or mixed traffic at random
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            run = $urandom_range(20, 60);
            for (k = 0; k < run && issued < RANDOM_ITEMS; k++) begin
                r = random_req(mode);
                add_req(r);
                if (r.req_type != REQ_UNUSED) issued++;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
